// File: hdl/lpg_pkg.sv
// shared constants and operation codes for the line pixel generator
package lpg_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEFAULT = 6;

  // guard bits on top of the coordinate width for the decision variable
  localparam int GUARD_BITS = 3;

  // shared unit operation codes
  localparam int OP_BITS = 2;
  localparam logic [OP_BITS-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_SUB     = 2'd1;
  localparam logic [OP_BITS-1:0] OP_ABSDIFF = 2'd2;

endpackage

// File: hdl/line_pixel_generator_core.sv
// top level: line segment rasterizer with setup sequencer and pixel stepper
//
// Takes one segment (two endpoints) per input beat and emits every pixel on it,
// one output beat per major-axis position, with last_pixel set on the final one.
// A segment passes through setup steps (two absolute differences, the steepness
// compare and two decision-variable terms, all on the one shared adder), then
// the pixel loop emits one pixel per cycle while the output register is free;
// a stall on the output side holds the loop. A segment yields major delta + 1
// pixels, at most 2^COORD_BITS. After loading the last pixel the sequencer
// returns to idle to take the next segment, so a new segment is not accepted
// before the previous one has been stepped through. The pixel loop reuses the
// same adder once per pixel to update the decision variable.
// in_ready is high only while the sequencer is idle; the final pixel may still
// sit in the output register when the next segment is accepted.
module line_pixel_generator_core #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  localparam int W  = COORD_BITS + lpg_pkg::GUARD_BITS;
  localparam int EW = W - COORD_BITS;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DX    = 3'd1;
  localparam logic [2:0] ST_DY    = 3'd2;
  localparam logic [2:0] ST_ORDER = 3'd3;
  localparam logic [2:0] ST_DINIT = 3'd4;
  localparam logic [2:0] ST_INCB  = 3'd5;
  localparam logic [2:0] ST_RUN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // captured endpoints
  logic [COORD_BITS-1:0] ax, ay, bx, by;

  // setup results
  logic [COORD_BITS-1:0] dx_abs, dy_abs;
  logic                  x_up, y_up;
  logic                  steep;
  logic [COORD_BITS-1:0] major_delta, minor_delta;

  // run state
  logic [COORD_BITS-1:0] major_pos, major_end, minor_pos;
  logic                  minor_down;
  logic signed [W-1:0]   dec;
  logic signed [W-1:0]   inc_a, inc_b;

  // shared unit hookup
  logic [lpg_pkg::OP_BITS-1:0] alu_op;
  logic signed [W-1:0]         alu_a, alu_b, alu_res;
  logic                        alu_neg;

  // output side
  logic                  out_free;
  logic                  pix_load;
  logic                  pix_last;
  logic [COORD_BITS-1:0] pix_x, pix_y;

  // ordering signals used in the order step
  logic                  steep_c;
  logic                  major_up_c, minor_up_c;
  logic [COORD_BITS-1:0] maj_a_c, maj_b_c, min_a_c, min_b_c;

  assign in_ready = (state == ST_IDLE);

  lpg_alu #(
    .WIDTH(W)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_res),
    .neg    (alu_neg)
  );

  // operand select for the shared unit
  always_comb begin
    alu_op = lpg_pkg::OP_ADD;
    alu_a  = dec;
    alu_b  = dec[W-1] ? inc_a : inc_b;
    unique case (state)
      ST_DX: begin
        alu_op = lpg_pkg::OP_ABSDIFF;
        alu_a  = {{EW{1'b0}}, ax};
        alu_b  = {{EW{1'b0}}, bx};
      end
      ST_DY: begin
        alu_op = lpg_pkg::OP_ABSDIFF;
        alu_a  = {{EW{1'b0}}, ay};
        alu_b  = {{EW{1'b0}}, by};
      end
      ST_ORDER: begin
        alu_op = lpg_pkg::OP_SUB;
        alu_a  = {{EW{1'b0}}, dx_abs};
        alu_b  = {{EW{1'b0}}, dy_abs};
      end
      ST_DINIT: begin
        alu_op = lpg_pkg::OP_SUB;
        alu_a  = {{(EW-1){1'b0}}, minor_delta, 1'b0};
        alu_b  = {{EW{1'b0}}, major_delta};
      end
      ST_INCB: begin
        alu_op = lpg_pkg::OP_SUB;
        alu_a  = {{(EW-1){1'b0}}, minor_delta, 1'b0};
        alu_b  = {{(EW-1){1'b0}}, major_delta, 1'b0};
      end
      ST_IDLE, ST_RUN: begin
        alu_op = lpg_pkg::OP_ADD;
        alu_a  = dec;
        alu_b  = dec[W-1] ? inc_a : inc_b;
      end
      default: begin
        alu_op = lpg_pkg::OP_ADD;
      end
    endcase
  end

  // axis choice from the steepness compare
  always_comb begin
    steep_c    = alu_neg;
    major_up_c = steep_c ? y_up : x_up;
    minor_up_c = steep_c ? x_up : y_up;
    maj_a_c    = steep_c ? ay : ax;
    maj_b_c    = steep_c ? by : bx;
    min_a_c    = steep_c ? ax : ay;
    min_b_c    = steep_c ? bx : by;
  end

  // pixel presented to the output register
  assign pix_x    = steep ? minor_pos : major_pos;
  assign pix_y    = steep ? major_pos : minor_pos;
  assign pix_last = (major_pos == major_end);
  assign pix_load = (state == ST_RUN) && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DX;
      ST_DX:    state_next = ST_DY;
      ST_DY:    state_next = ST_ORDER;
      ST_ORDER: state_next = ST_DINIT;
      ST_DINIT: state_next = ST_INCB;
      ST_INCB:  state_next = ST_RUN;
      ST_RUN:   if (pix_load && pix_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ax <= start_x;
          ay <= start_y;
          bx <= end_x;
          by <= end_y;
        end
      end
      ST_DX: begin
        dx_abs <= alu_res[COORD_BITS-1:0];
        x_up   <= alu_neg;
      end
      ST_DY: begin
        dy_abs <= alu_res[COORD_BITS-1:0];
        y_up   <= alu_neg;
      end
      ST_ORDER: begin
        // swap endpoints so the major coordinate runs upward
        steep       <= steep_c;
        major_delta <= steep_c ? dy_abs : dx_abs;
        minor_delta <= steep_c ? dx_abs : dy_abs;
        major_pos   <= major_up_c ? maj_a_c : maj_b_c;
        major_end   <= major_up_c ? maj_b_c : maj_a_c;
        minor_pos   <= major_up_c ? min_a_c : min_b_c;
        minor_down  <= major_up_c ? !minor_up_c : minor_up_c;
      end
      ST_DINIT: begin
        dec   <= alu_res;
        inc_a <= {{(EW-1){1'b0}}, minor_delta, 1'b0};
      end
      ST_INCB: begin
        inc_b <= alu_res;
      end
      ST_RUN: begin
        // one pixel step: advance major, maybe minor, update decision
        if (pix_load && !pix_last) begin
          major_pos <= major_pos + 1'b1;
          dec       <= alu_res;
          if (!dec[W-1]) begin
            minor_pos <= minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  lpg_out_reg #(
    .COORD_BITS(COORD_BITS)
  ) u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (pix_load),
    .load_x     (pix_x),
    .load_y     (pix_y),
    .load_last  (pix_last),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule

// File: hdl/lpg_alu.sv
// shared add, subtract and absolute-difference unit
module lpg_alu #(
  parameter int WIDTH = lpg_pkg::COORD_BITS_DEFAULT + lpg_pkg::GUARD_BITS
) (
  input  logic [lpg_pkg::OP_BITS-1:0] op,
  input  logic signed [WIDTH-1:0]     a,
  input  logic signed [WIDTH-1:0]     b,
  output logic signed [WIDTH-1:0]     result,
  output logic                        neg
);

  logic signed [WIDTH-1:0] diff;
  logic signed [WIDTH-1:0] sum;

  assign diff = a - b;
  assign sum  = a + b;

  // result select; neg is the sign of the raw result, or a < b for absdiff
  always_comb begin
    unique case (op)
      lpg_pkg::OP_ADD: begin
        result = sum;
        neg    = sum[WIDTH-1];
      end
      lpg_pkg::OP_SUB: begin
        result = diff;
        neg    = diff[WIDTH-1];
      end
      lpg_pkg::OP_ABSDIFF: begin
        result = diff[WIDTH-1] ? (b - a) : diff;
        neg    = diff[WIDTH-1];
      end
      default: begin
        result = diff;
        neg    = diff[WIDTH-1];
      end
    endcase
  end

endmodule

// File: hdl/lpg_out_reg.sv
// output register holding one pixel beat until it is taken
module lpg_out_reg #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [COORD_BITS-1:0] load_x,
  input  logic [COORD_BITS-1:0] load_y,
  input  logic                  load_last,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);

  // slot can take a new beat when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x    <= load_x;
      pixel_y    <= load_y;
      last_pixel <= load_last;
    end
  end

endmodule

// File: tb/line_pixel_generator_core_tb.sv
// testbench for the line pixel generator: directed and random segments checked per pixel
module line_pixel_generator_core_tb;

  localparam int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT;
  localparam int NUM_DIRECTED = 18;
  localparam int NUM_RANDOM = 312;
  localparam int CALM_TAIL = 30;
  localparam int DRAIN_CYCLES = 5 + (1 << COORD_BITS) + 16;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   single;
  } seg_row_t;

  // directed segments; one-point rows carry their own expected pixel
  seg_row_t directed_rows [NUM_DIRECTED] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1},
    '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1},
    '{6'd21, 6'd42, 6'd21, 6'd42, 1'b1},
    '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0},
    '{6'd63, 6'd5,  6'd0,  6'd5,  1'b0},
    '{6'd7,  6'd0,  6'd7,  6'd63, 1'b0},
    '{6'd7,  6'd63, 6'd7,  6'd0,  1'b0},
    '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0},
    '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0},
    '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0},
    '{6'd0,  6'd40, 6'd50, 6'd3,  1'b0},
    '{6'd10, 6'd0,  6'd30, 6'd63, 1'b0},
    '{6'd30, 6'd63, 6'd10, 6'd0,  1'b0},
    '{6'd5,  6'd5,  6'd6,  6'd7,  1'b0},
    '{6'd5,  6'd5,  6'd7,  6'd6,  1'b0},
    '{6'd0,  6'd0,  6'd1,  6'd0,  1'b0},
    '{6'd42, 6'd21, 6'd21, 6'd42, 1'b0}
  };

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  pixel_t pixel_q [$];
  int     errors = 0;
  int     segments_sent = 0;
  int     pixels_checked = 0;
  int     idle_pct = 0;
  int     stall_left = 0;

  line_pixel_generator_core #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last_pixel(last_pixel)
  );

  always #5 clk = ~clk;

  // expected pixel run of one segment, error-accumulator stepping along the major axis
  function automatic void rasterize_segment(input coord_t sx, input coord_t sy,
                                            input coord_t ex, input coord_t ey);
    coord_t maj_pos, maj_end, min_pos, min_end, tmp;
    logic   steep, down, done;
    int     dmaj, dmin, acc, n;
    pixel_t px;
    steep = ((sy > ey) ? sy - ey : ey - sy) > ((sx > ex) ? sx - ex : ex - sx);
    maj_pos = steep ? sy : sx;
    min_pos = steep ? sx : sy;
    maj_end = steep ? ey : ex;
    min_end = steep ? ex : ey;
    if (maj_pos > maj_end) begin
      tmp = maj_pos; maj_pos = maj_end; maj_end = tmp;
      tmp = min_pos; min_pos = min_end; min_end = tmp;
    end
    dmaj = int'(maj_end) - int'(maj_pos);
    dmin = (min_end > min_pos) ? int'(min_end) - int'(min_pos) : int'(min_pos) - int'(min_end);
    down = !(min_pos < min_end);
    acc = 0;
    n = 0;
    done = 1'b0;
    while (!done) begin
      px.x = steep ? min_pos : maj_pos;
      px.y = steep ? maj_pos : min_pos;
      px.last = (maj_pos == maj_end);
      pixel_q.push_back(px);
      n++;
      acc += dmin;
      if (2 * acc >= dmaj) begin
        min_pos = down ? min_pos - 1'b1 : min_pos + 1'b1;
        acc -= dmaj;
      end
      if (px.last || n >= (1 << COORD_BITS)) done = 1'b1;
      else maj_pos = maj_pos + 1'b1;
    end
  endfunction

  // present one segment from a falling edge, hold it until accepted, return at a falling edge
  task automatic drive_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                               input coord_t ey, input logic single);
    pixel_t px;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    start_x <= sx;
    start_y <= sy;
    end_x <= ex;
    end_y <= ey;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (single) begin
      px.x = sx;
      px.y = sy;
      px.last = 1'b1;
      pixel_q.push_back(px);
    end else begin
      rasterize_segment(sx, sy, ex, ey);
    end
    segments_sent++;
    @(negedge clk);
  endtask

  // output side stalls in bursts of random length when idle_pct is nonzero
  always @(negedge clk) begin
    if (rst || idle_pct == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every output beat against the oldest expected pixel
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d last=%0d", pixel_x, pixel_y, last_pixel);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
          errors++;
        end
        if (pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
          errors++;
        end
        if (last_pixel !== want.last) begin
          $error("last_pixel: expected %0d, got %0d", want.last, last_pixel);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    coord_t sx, sy, ex, ey;
    int     len;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    if (out_valid !== 1'b0) begin
      $error("out_valid: expected 0, got %0d", out_valid);
      errors++;
    end
    @(negedge clk);

    // directed segments, no idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      drive_segment(directed_rows[i].sx, directed_rows[i].sy, directed_rows[i].ex,
                    directed_rows[i].ey, directed_rows[i].single);
    end

    // random segments, mostly short to keep runs brief
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= NUM_RANDOM - CALM_TAIL) begin
        idle_pct = 0;
      end else if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0, 1: begin
          ex = $urandom_range(0, 63);
          ey = $urandom_range(0, 63);
        end
        2: begin
          ex = sx;
          ey = sy;
        end
        3: begin
          // axis-aligned or exact diagonal
          len = $urandom_range(0, 20) - 10;
          case ($urandom_range(0, 2))
            0: begin ex = coord_t'(sx + len); ey = sy; end
            1: begin ex = sx; ey = coord_t'(sy + len); end
            default: begin ex = coord_t'(sx + len); ey = coord_t'(sy - len); end
          endcase
        end
        default: begin
          ex = coord_t'(sx + $urandom_range(0, 14) - 7);
          ey = coord_t'(sy + $urandom_range(0, 14) - 7);
        end
      endcase
      drive_segment(sx, sy, ex, ey, 1'b0);
    end
    in_valid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d segments (directed extremes, ties, reversals, random mix)",
             segments_sent);
    $display("checked %0d pixels against the predicted runs", pixels_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #15_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
